// ----- src/pkpt_pkg.sv -----
// ----------------------------------------------------------------------------
// pkpt_pkg
// Shared types and codes for the peer key pin table.
// ----------------------------------------------------------------------------
package pkpt_pkg;

	localparam int unsigned PEER_SLOTS_DEF = 16;

	localparam logic CMD_INGEST = 1'b0;
	localparam logic CMD_CLEAR  = 1'b1;

	localparam logic [1:0] ST_ACCEPTED     = 2'd0;
	localparam logic [1:0] ST_KEY_MISMATCH = 2'd1;
	localparam logic [1:0] ST_CLEARED      = 2'd2;

	localparam logic [31:0] SEQ_WRAP = 32'h0001_0000;

	typedef struct packed {
		logic        cmd;
		logic [63:0] node_id;
		logic [63:0] key_word0;
		logic [63:0] key_word1;
		logic [63:0] key_word2;
		logic [63:0] key_word3;
		logic [15:0] wire_seq;
		logic [31:0] uptime_s;
	} pkpt_in_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        new_peer;
		logic        evicted;
		logic        seq_old;
		logic [31:0] location_seq;
	} pkpt_out_t;

	typedef struct packed {
		logic load;
		logic clear;
		logic scan;
		logic decide;
	} pkpt_ctl_t;

	typedef struct packed {
		logic scan_done;
	} pkpt_stat_t;

endpackage

// ----- src/pkpt_ctrl.sv -----
// ----------------------------------------------------------------------------
// pkpt_ctrl
// Sequencer for the peer key pin table: accept, clear, scan, decide.
// ----------------------------------------------------------------------------
module pkpt_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic                   cmd,
	input  pkpt_pkg::pkpt_stat_t   stat,
	output pkpt_pkg::pkpt_ctl_t    ctl,
	output logic                   busy
);
	import pkpt_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_CLEAR  = 4'b0010,
		S_SCAN   = 4'b0100,
		S_DECIDE = 4'b1000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = (cmd == CMD_CLEAR) ? S_CLEAR : S_SCAN;
				end
			end
			S_CLEAR:  state_d = S_IDLE;
			S_SCAN: begin
				if (stat.scan_done) begin
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy       = (state_q != S_IDLE);
	assign ctl.load   = (state_q == S_IDLE) && start;
	assign ctl.clear  = (state_q == S_CLEAR);
	assign ctl.scan   = (state_q == S_SCAN);
	assign ctl.decide = (state_q == S_DECIDE);

endmodule

// ----- src/pkpt_datapath.sv -----
// ----------------------------------------------------------------------------
// pkpt_datapath
// Slot memory, valid bits, scan trackers and the update/result logic.
// ----------------------------------------------------------------------------
module pkpt_datapath #(
	parameter int unsigned PEER_SLOTS = pkpt_pkg::PEER_SLOTS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  pkpt_pkg::pkpt_ctl_t    ctl,
	output pkpt_pkg::pkpt_stat_t   stat,
	input  pkpt_pkg::pkpt_in_t     in_item,
	output logic                   done,
	output pkpt_pkg::pkpt_out_t    result
);
	import pkpt_pkg::*;

	localparam int IDX_W = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;
	localparam int CNT_W = $clog2(PEER_SLOTS + 1);
	localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(PEER_SLOTS - 1);
	localparam logic [CNT_W-1:0] SLOT_CNT  = CNT_W'(PEER_SLOTS);

	typedef struct packed {
		logic [63:0] id;
		logic [63:0] k0;
		logic [63:0] k1;
		logic [63:0] k2;
		logic [63:0] k3;
		logic [15:0] seq;
		logic [31:0] ext;
		logic [31:0] seen;
	} ent_t;

	ent_t mem [PEER_SLOTS];

	pkpt_in_t              req_q;
	logic [PEER_SLOTS-1:0] valid_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  rd_vld_s1;
	logic                  rd_valid_s1;
	logic [IDX_W-1:0]      rd_idx_s1;
	ent_t                  rd_ent_s1;
	logic                  hit_q;
	logic [IDX_W-1:0]      hit_idx_q;
	ent_t                  hit_ent_q;
	logic                  free_q;
	logic [IDX_W-1:0]      free_idx_q;
	logic                  old_q;
	logic [IDX_W-1:0]      old_idx_q;
	logic [31:0]           old_seen_q;
	logic                  done_q;
	pkpt_out_t             res_q;

	logic             issue;
	logic [IDX_W-1:0] issue_idx;
	logic             cmp_on;
	logic             hit_now;
	logic [31:0]      seen_diff;
	logic             key_ok;
	logic [31:0]      ext_base;
	logic [31:0]      ext_new;
	logic [15:0]      seq_diff;
	logic             seq_newer;
	logic             wr_en;
	logic [IDX_W-1:0] wr_idx;
	ent_t             wr_ent;
	pkpt_out_t        res_d;

	assign issue     = ctl.scan && (cnt_q < SLOT_CNT);
	assign issue_idx = cnt_q[IDX_W-1:0];

	assign cmp_on    = ctl.scan && rd_vld_s1;
	assign hit_now   = cmp_on && rd_valid_s1 && (rd_ent_s1.id == req_q.node_id);
	assign seen_diff = rd_ent_s1.seen - old_seen_q;
	assign stat.scan_done = hit_now || (cmp_on && (rd_idx_s1 == LAST_IDX));

	assign key_ok    = ({hit_ent_q.k0, hit_ent_q.k1, hit_ent_q.k2, hit_ent_q.k3} ==
		{req_q.key_word0, req_q.key_word1, req_q.key_word2, req_q.key_word3});
	assign ext_base  = {hit_ent_q.ext[31:16], req_q.wire_seq};
	assign ext_new   = (req_q.wire_seq < hit_ent_q.ext[15:0]) ? ext_base + SEQ_WRAP : ext_base;
	assign seq_diff  = req_q.wire_seq - hit_ent_q.seq;
	assign seq_newer = (req_q.wire_seq != hit_ent_q.seq) && !seq_diff[15];

	assign wr_en  = ctl.decide && (!hit_q || key_ok);
	assign wr_idx = hit_q ? hit_idx_q : (free_q ? free_idx_q : old_idx_q);

	always_comb begin
		wr_ent.id   = req_q.node_id;
		wr_ent.k0   = req_q.key_word0;
		wr_ent.k1   = req_q.key_word1;
		wr_ent.k2   = req_q.key_word2;
		wr_ent.k3   = req_q.key_word3;
		wr_ent.seq  = req_q.wire_seq;
		wr_ent.ext  = hit_q ? ext_new : {16'h0000, req_q.wire_seq};
		wr_ent.seen = req_q.uptime_s;
	end

	always_comb begin
		res_d = '0;
		if (ctl.clear) begin
			res_d.status = ST_CLEARED;
		end else if (hit_q && !key_ok) begin
			res_d.status = ST_KEY_MISMATCH;
		end else if (hit_q) begin
			res_d.status       = ST_ACCEPTED;
			res_d.seq_old      = !seq_newer;
			res_d.location_seq = ext_new;
		end else begin
			res_d.status       = ST_ACCEPTED;
			res_d.new_peer     = 1'b1;
			res_d.evicted      = !free_q;
			res_d.location_seq = {16'h0000, req_q.wire_seq};
		end
	end

	// slot memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_ent;
		end
		if (issue) begin
			rd_ent_s1 <= mem[issue_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			cnt_q     <= '0;
			rd_vld_s1 <= 1'b0;
			hit_q     <= 1'b0;
			free_q    <= 1'b0;
			old_q     <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			done_q <= ctl.clear || ctl.decide;
			if (ctl.clear) begin
				valid_q <= '0;
			end else if (wr_en) begin
				valid_q[wr_idx] <= 1'b1;
			end
			rd_vld_s1 <= issue;
			if (ctl.load) begin
				cnt_q  <= '0;
				hit_q  <= 1'b0;
				free_q <= 1'b0;
				old_q  <= 1'b0;
			end else begin
				if (issue) begin
					cnt_q <= cnt_q + 1'b1;
				end
				if (hit_now) begin
					hit_q <= 1'b1;
				end
				if (cmp_on && !rd_valid_s1) begin
					free_q <= 1'b1;
				end
				if (cmp_on && rd_valid_s1) begin
					old_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			req_q <= in_item;
		end
		if (issue) begin
			rd_idx_s1   <= issue_idx;
			rd_valid_s1 <= valid_q[issue_idx];
		end
		if (hit_now) begin
			hit_idx_q <= rd_idx_s1;
			hit_ent_q <= rd_ent_s1;
		end
		if (cmp_on && !rd_valid_s1 && !free_q) begin
			free_idx_q <= rd_idx_s1;
		end
		// keep the oldest valid slot, lowest index on ties
		if (cmp_on && rd_valid_s1 && (!old_q || seen_diff[31])) begin
			old_idx_q  <= rd_idx_s1;
			old_seen_q <= rd_ent_s1.seen;
		end
		if (ctl.clear || ctl.decide) begin
			res_q <= res_d;
		end
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

// ----- src/peer_key_pin_table.sv -----
// ----------------------------------------------------------------------------
// peer_key_pin_table
// Pinned peer key table: look up, check, insert or evict on each announce.
// ----------------------------------------------------------------------------
// A beat is taken when start is high and busy is low; busy stays high until
// the result beat, which is shown on result for exactly one cycle with done
// high and cannot be held off. A clear command passes through the clear state
// before its result is registered. An announce scans the slot memory one slot per
// cycle and stops at the matching slot or after the last slot, then passes through
// the decide state before its result is registered. busy drops in the cycle the
// result is shown, so the next beat may be taken then.
// ----------------------------------------------------------------------------
module peer_key_pin_table #(
	parameter int unsigned PEER_SLOTS = pkpt_pkg::PEER_SLOTS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  pkpt_pkg::pkpt_in_t   in_item,
	output logic                 done,
	output pkpt_pkg::pkpt_out_t  result
);
	import pkpt_pkg::*;

	pkpt_ctl_t  ctl;
	pkpt_stat_t stat;

	pkpt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (in_item.cmd),
		.stat   (stat),
		.ctl    (ctl),
		.busy   (busy)
	);

	pkpt_datapath #(
		.PEER_SLOTS (PEER_SLOTS)
	) u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.stat    (stat),
		.in_item (in_item),
		.done    (done),
		.result  (result)
	);

endmodule

// ----- src/pkpt_checker.sv -----
// ----------------------------------------------------------------------------
// pkpt_checker
// Port-level checks on the peer key pin table, bound to the top level.
// ----------------------------------------------------------------------------
module pkpt_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 start,
	input logic                 busy,
	input logic                 done,
	input pkpt_pkg::pkpt_out_t  result
);
	import pkpt_pkg::*;

	// a taken beat holds the block busy in the next cycle
	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after a beat was taken");

	// result beats never come back to back
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("two result beats in a row");

	// the block is free again when it shows a result
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("busy still high during a result beat");

	// a clear result carries no peer information
	a_clear_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (result.status == ST_CLEARED) |->
		!result.new_peer && !result.evicted && !result.seq_old &&
		(result.location_seq == 32'h0))
		else $error("clear result with nonzero fields");

	// a new peer is always accepted and never stale
	a_new_peer: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.new_peer |-> (result.status == ST_ACCEPTED) && !result.seq_old)
		else $error("new peer result inconsistent");

endmodule

bind peer_key_pin_table pkpt_checker u_pkpt_checker (.*);

// ----- verif/peer_key_pin_table_test.sv -----
// ----------------------------------------------------------------------------
// peer_key_pin_table_test
// Drives clear commands and announces into the pinned peer key table and
// compares each result beat against a cycle-free table predictor kept in a
// small scoreboard. A directed opening covers the field extremes, sequence
// staleness and rollover, key mismatches, a full table and an eviction tie.
// Random traffic follows from a pool of recurring identities, with fresh
// identities, rekeys, wrapping clocks and gaps of random length.
// ----------------------------------------------------------------------------
module peer_key_pin_table_test;
	import pkpt_pkg::*;

	localparam int POOL         = 24;
	localparam int RANDOM_ITEMS = 2000;

	class pin_table_scoreboard;
		bit         occupied [PEER_SLOTS_DEF];
		bit [63:0]  peer_id  [PEER_SLOTS_DEF];
		bit [255:0] pin_key  [PEER_SLOTS_DEF];
		bit [31:0]  ext_seq  [PEER_SLOTS_DEF];
		bit [31:0]  last_seen[PEER_SLOTS_DEF];

		pkpt_out_t expected_outcomes[$];

		int unsigned errors, checked, clears, mismatches, new_peers, evictions;
		int unsigned stale, rollovers;

		function void note_item(pkpt_in_t it);
			pkpt_out_t  o;
			bit [255:0] key;
			bit [31:0]  ext;
			bit [31:0]  age;
			bit [15:0]  d;
			int         hit;
			int         s;
			o = '0;
			hit = -1;
			s = -1;
			key = {it.key_word0, it.key_word1, it.key_word2, it.key_word3};
			if (it.cmd == CMD_CLEAR) begin
				foreach (occupied[i]) occupied[i] = 1'b0;
				o.status = ST_CLEARED;
				clears++;
			end else begin
				for (int i = 0; i < PEER_SLOTS_DEF; i++)
					if (hit < 0 && occupied[i] && peer_id[i] == it.node_id) hit = i;
				if (hit >= 0 && pin_key[hit] != key) begin
					o.status = ST_KEY_MISMATCH;
					mismatches++;
				end else if (hit >= 0) begin
					ext = {ext_seq[hit][31:16], it.wire_seq};
					if (it.wire_seq < ext_seq[hit][15:0]) begin
						ext += SEQ_WRAP;
						rollovers++;
					end
					d = it.wire_seq - ext_seq[hit][15:0];
					o.status = ST_ACCEPTED;
					o.seq_old = (it.wire_seq == ext_seq[hit][15:0]) || (d >= 16'h8000);
					o.location_seq = ext;
					if (o.seq_old) stale++;
					ext_seq[hit] = ext;
					last_seen[hit] = it.uptime_s;
				end else begin
					for (int i = 0; i < PEER_SLOTS_DEF; i++)
						if (s < 0 && !occupied[i]) s = i;
					if (s < 0) begin
						s = 0;
						for (int i = 1; i < PEER_SLOTS_DEF; i++) begin
							age = last_seen[i] - last_seen[s];
							if (age[31]) s = i;
						end
					end
					o.status = ST_ACCEPTED;
					o.new_peer = 1'b1;
					o.evicted = occupied[s];
					o.location_seq = {16'h0000, it.wire_seq};
					new_peers++;
					if (occupied[s]) evictions++;
					occupied[s] = 1'b1;
					peer_id[s] = it.node_id;
					pin_key[s] = key;
					ext_seq[s] = {16'h0000, it.wire_seq};
					last_seen[s] = it.uptime_s;
				end
			end
			expected_outcomes.push_back(o);
		endfunction

		function void compare_field(string name, bit [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
				errors++;
			end
		endfunction

		function void check_outcome(pkpt_out_t got);
			pkpt_out_t want;
			if (expected_outcomes.size() == 0) begin
				$error("result beat with no outstanding announce or clear");
				errors++;
				return;
			end
			want = expected_outcomes.pop_front();
			checked++;
			compare_field("status", 32'(want.status), 32'(got.status));
			compare_field("new_peer", 32'(want.new_peer), 32'(got.new_peer));
			compare_field("evicted", 32'(want.evicted), 32'(got.evicted));
			compare_field("seq_old", 32'(want.seq_old), 32'(got.seq_old));
			compare_field("location_seq", want.location_seq, got.location_seq);
		endfunction
	endclass

	logic      clk;
	logic      arst_n;
	logic      start;
	logic      busy;
	pkpt_in_t  in_item;
	logic      done;
	pkpt_out_t result;

	pin_table_scoreboard board = new();

	bit [63:0]  pool_id [POOL];
	bit [255:0] pool_key[POOL];
	bit [15:0]  pool_seq[POOL];
	bit [31:0]  now_s;

	peer_key_pin_table dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.in_item(in_item),
		.done   (done),
		.result (result)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	always @(posedge clk) begin
		if (arst_n && done) board.check_outcome(result);
	end

	function automatic bit [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic pkpt_in_t announce(bit [63:0] id, bit [255:0] key, bit [15:0] seq,
			bit [31:0] up);
		pkpt_in_t it;
		it.cmd = CMD_INGEST;
		it.node_id = id;
		{it.key_word0, it.key_word1, it.key_word2, it.key_word3} = key;
		it.wire_seq = seq;
		it.uptime_s = up;
		return it;
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 70) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic pkpt_in_t random_item();
		pkpt_in_t    it;
		int unsigned roll, sroll, troll, p;
		bit [255:0]  key;
		bit [15:0]   s;
		roll = $urandom_range(0, 99);
		p = $urandom_range(0, POOL - 1);
		if (roll >= 90 && roll < 93)
			pool_key[p] = {rand64(), rand64(), rand64(), rand64()};
		it.cmd = (roll < 3) ? CMD_CLEAR : CMD_INGEST;
		it.node_id = pool_id[p];
		key = pool_key[p];
		if (roll >= 3 && roll < 11) key ^= 256'b1 << $urandom_range(0, 255);
		if (roll >= 11 && roll < 26) begin
			it.node_id = rand64();
			key = {rand64(), rand64(), rand64(), rand64()};
		end
		{it.key_word0, it.key_word1, it.key_word2, it.key_word3} = key;

		sroll = $urandom_range(0, 99);
		if (sroll < 50) s = pool_seq[p] + 16'($urandom_range(1, 200));
		else if (sroll < 65) s = pool_seq[p] - 16'($urandom_range(0, 3));
		else if (sroll < 75) s = pool_seq[p] + 16'h8000;
		else if (sroll < 85) s = pool_seq[p] + 16'h7fff;
		else s = 16'($urandom);
		pool_seq[p] = s;
		it.wire_seq = s;

		troll = $urandom_range(0, 99);
		if (troll < 70) now_s += $urandom_range(0, 3);
		else if (troll < 80) now_s += $urandom_range(0, 32'h7fff_ffff);
		if (troll >= 80 && troll < 95) it.uptime_s = now_s - $urandom_range(0, 1000);
		else if (troll >= 95) it.uptime_s = $urandom;
		else it.uptime_s = now_s;
		return it;
	endfunction

	task automatic send_item(input pkpt_in_t it, input int unsigned gap);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		in_item <= it;
		do @(posedge clk); while (busy);
		board.note_item(it);
	endtask

	// hold off until every outstanding beat has come back
	task automatic wait_drained();
		start <= 1'b0;
		do @(posedge clk); while (board.expected_outcomes.size() != 0);
	endtask

	initial begin
		#20_000_000;
		$display("tb: failure");
		$finish;
	end

	initial begin
		pkpt_in_t   clr;
		bit [255:0] ones;
		bit         calm;
		arst_n <= 1'b0;
		start <= 1'b0;
		in_item <= '0;
		clr = '1;
		ones = '1;
		calm = 1'b0;
		now_s = 32'hffff_f000;
		for (int p = 0; p < POOL; p++) begin
			pool_id[p] = rand64();
			pool_key[p] = {rand64(), rand64(), rand64(), rand64()};
			pool_seq[p] = 16'($urandom);
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(clr, 0);
		send_item(announce(64'd0, 256'd0, 16'h0000, 32'h0000_0000), 0);
		send_item(announce('1, ones, 16'hffff, 32'hffff_ffff), 0);
		send_item(announce(64'd0, 256'd0, 16'h0001, 32'h8000_0000), 0);
		send_item(announce(64'd0, 256'd0, 16'h0001, 32'h8000_0000), 0);
		send_item(announce(64'd0, 256'd0, 16'h0000, 32'h8000_0000), 0);
		send_item(announce(64'd0, 256'd0, 16'h8000, 32'h8000_0000), 0);
		send_item(announce(64'd0, 256'd0, 16'hffff, 32'h8000_0000), 0);
		send_item(announce('1, ones, 16'h0000, 32'h8000_0000), 0);
		send_item(announce(64'd0, 256'd1, 16'h0005, 32'h8000_0000), 0);
		send_item(announce('1, ones ^ (256'b1 << 255), 16'h0005, 32'h8000_0000), 0);
		for (int i = 2; i < PEER_SLOTS_DEF; i++)
			send_item(announce(64'h100 + i, {rand64(), rand64(), rand64(), rand64()},
				16'(i), 32'h8000_0000), 0);
		send_item(announce(64'h5a5a_a5a5_0f0f_f0f0, {rand64(), rand64(), rand64(), rand64()},
			16'h1234, 32'h8000_0001), 0);
		wait_drained();

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 100 == 0) calm = ($urandom_range(0, 3) == 0);
			if (n % 500 == 250) wait_drained();
			send_item(random_item(), calm ? 0 : pick_gap());
		end

		wait_drained();
		repeat (PEER_SLOTS_DEF + 8) @(posedge clk);

		$display("summary: %0d results checked, %0d clears, %0d new peers, %0d evictions",
			board.checked, board.clears, board.new_peers, board.evictions);
		$display("summary: %0d key mismatches, %0d stale sequences, %0d sequence rollovers",
			board.mismatches, board.stale, board.rollovers);
		if (board.errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end
endmodule

// ----- peer_key_pin_table.f -----
src/pkpt_pkg.sv
src/pkpt_ctrl.sv
src/pkpt_datapath.sv
src/peer_key_pin_table.sv
src/pkpt_checker.sv
verif/peer_key_pin_table_test.sv
